### hw/rtl/rphd_pkg.sv
// Shared types, constants and character helpers for the raw profile hex text decoder.
// Used by every module of the block and by its checker; depends on nothing.
package rphd_pkg;

  localparam int MAX_PAYLOAD = 65536;
  // Length accumulator saturates at MAX_PAYLOAD + 1, so it must hold that value.
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 2);
  localparam int IDX_W = 16;
  localparam int CNT_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PAYLOAD);

  localparam logic [1:0] CP_SAT = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_NAME  = 3'd1,
    PH_LWS   = 3'd2,
    PH_LSIGN = 3'd3,
    PH_LDIG  = 3'd4,
    PH_HEX1  = 3'd5,
    PH_HEX2  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    ST_BUSY      = 4'd0,
    ST_OK        = 4'd1,
    ST_EMPTY     = 4'd2,
    ST_MALFORMED = 4'd3,
    ST_TRUNC     = 4'd4,
    ST_BADLEN    = 4'd5,
    ST_BADTOKEN  = 4'd6,
    ST_SHORT     = 4'd7,
    ST_IGNORED   = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic             byte_valid;
    logic [7:0]       byte_value;
    logic [IDX_W-1:0] byte_index;
    status_t          status;
  } out_item_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_UA) && (c <= CH_UF)) || ((c >= CH_LA) && (c <= CH_LF));
  endfunction

  // Nibble value of a hex digit; meaningless for other characters.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= CH_UA) && (c <= CH_UF)) begin
      v = c - CH_UA + HEX_ALPHA_BASE;
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      v = c - CH_LA + HEX_ALPHA_BASE;
    end else begin
      v = c - CH_0;
    end
    return v[3:0];
  endfunction

endpackage

### hw/rtl/rphd_in_if.sv
// Input channel of the decoder: valid/ready handshake with one character per transaction.
// Stands alone; the payload widths match rphd_pkg::in_item_t.
interface rphd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_char;

  modport source (output valid, output ch, output final_char, input ready);
  modport sink   (input valid, input ch, input final_char, output ready);
endinterface

### hw/rtl/rphd_out_if.sv
// Result channel of the decoder: valid/ready handshake with one result per transaction.
// Stands alone; the payload widths match rphd_pkg::out_item_t.
interface rphd_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic [15:0] byte_index;
  logic [3:0]  status;

  modport source (output valid, output byte_valid, output byte_value, output byte_index,
                  output status, input ready);
  modport sink   (input valid, input byte_valid, input byte_value, input byte_index,
                  input status, output ready);
endinterface

### hw/rtl/rphd_in_stage.sv
// Input register of the decoder: captures one character transaction and holds it.
// Depends on rphd_pkg and rphd_in_if.
module rphd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  rphd_in_if.sink           in_chan,
  input  logic              advance,
  output rphd_pkg::in_item_t item,
  output logic              hold_valid
);
  import rphd_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Take a new character when empty, or whenever the held one leaves in this cycle.
  assign in_chan.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.ch         <= in_chan.ch;
      item_r.final_char <= in_chan.final_char;
    end
  end

  assign item       = item_r;
  assign hold_valid = valid_r;
endmodule

### hw/rtl/rphd_parse.sv
// Parser state and single-pass step logic: one character in, one result out.
// Depends on rphd_pkg.
module rphd_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  rphd_pkg::in_item_t  item,
  input  logic                advance,
  output rphd_pkg::out_item_t result
);
  import rphd_pkg::*;

  phase_t           phase_r, phase_nxt, phase_raw, phase_step;
  logic [1:0]       cp_r, cp_nxt, cp_step, cp_inc;
  logic [CNT_W-1:0] dl_r, dl_nxt, dl_step;
  logic             neg_r, neg_nxt, neg_step;
  logic [CNT_W-1:0] bd_r, bd_nxt, bd_step, bd_inc;
  logic [3:0]       hn_r, hn_nxt, hn_step;
  logic             ns_r, ns_nxt, ns_step;
  status_t          char_st;

  logic             c_nz, ended, is_nl, dig_ok, hex_ok;
  logic [3:0]       dig_val, hex_val;
  logic [CNT_W+3:0] acc;
  logic [CNT_W-1:0] acc_sat;
  logic             len_bad, len_bad_step;

  // Character decode and the multiply-by-ten accumulate.
  always_comb begin
    c_nz    = (item.ch != CH_NUL);
    ended   = item.final_char || !c_nz;
    is_nl   = (item.ch == CH_NL);
    dig_ok  = is_digit(item.ch);
    dig_val = 4'(item.ch - CH_0);
    hex_ok  = is_hex(item.ch);
    hex_val = hex_value(item.ch);
    cp_inc  = (cp_r == CP_SAT) ? cp_r : cp_r + 2'd1;
    bd_inc  = bd_r + 1'b1;
    acc     = ({4'b0, dl_r} << 3) + ({4'b0, dl_r} << 1) + (CNT_W+4)'(dig_val);
    acc_sat = (acc > (CNT_W+4)'(MAX_LEN)) ? MAX_LEN + 1'b1 : acc[CNT_W-1:0];
    len_bad = neg_r || (dl_r == '0) || (dl_r > MAX_LEN);
  end

  // Per-character effect on the state and the verdict it triggers.
  always_comb begin
    phase_raw = phase_r;
    cp_step   = cp_r;
    dl_step   = dl_r;
    neg_step  = neg_r;
    bd_step   = bd_r;
    hn_step   = hn_r;
    ns_step   = ns_r;
    char_st   = ST_BUSY;
    if (c_nz) begin
      cp_step = cp_inc;
      unique case (phase_r)
        PH_LEAD: begin
          if ((cp_inc == 2'd1) && is_nl) phase_raw = PH_NAME;
          else if (cp_inc == CP_SAT) char_st = ST_MALFORMED;
        end
        PH_NAME: begin
          if (is_nl) phase_raw = PH_LWS;
        end
        PH_LWS: begin
          priority if (is_space(item.ch)) begin
            phase_raw = PH_LWS;
          end else if ((item.ch == CH_PLUS) || (item.ch == CH_MINUS)) begin
            neg_step  = (item.ch == CH_MINUS);
            phase_raw = PH_LSIGN;
          end else if (dig_ok) begin
            dl_step   = CNT_W'(dig_val);
            phase_raw = PH_LDIG;
          end else begin
            char_st = ST_BADLEN;
          end
        end
        PH_LSIGN: begin
          if (dig_ok) begin
            dl_step   = CNT_W'(dig_val);
            phase_raw = PH_LDIG;
          end else begin
            char_st = ST_BADLEN;
          end
        end
        PH_LDIG: begin
          priority if (dig_ok) begin
            dl_step = acc_sat;
          end else if (len_bad) begin
            char_st = ST_BADLEN;
          end else if (!is_nl) begin
            char_st = ST_MALFORMED;
          end else begin
            phase_raw = PH_HEX1;
            ns_step   = 1'b0;
          end
        end
        PH_HEX1: begin
          priority if (is_nl) begin
            ns_step = 1'b1;
          end else if (hex_ok) begin
            hn_step   = hex_val;
            phase_raw = PH_HEX2;
          end else begin
            char_st = ST_BADTOKEN;
          end
        end
        PH_HEX2: begin
          if (hex_ok) begin
            bd_step   = bd_inc;
            ns_step   = 1'b0;
            phase_raw = PH_HEX1;
            if (bd_inc >= dl_r) char_st = ST_OK;
          end else begin
            char_st = ST_BADTOKEN;
          end
        end
        PH_DONE: begin
          char_st = ST_IGNORED;
        end
      endcase
    end
  end

  // Next state: any verdict closes the text; end of text returns to reset values.
  always_comb begin
    phase_step = (char_st != ST_BUSY) ? PH_DONE : phase_raw;
    if (ended) begin
      phase_nxt = PH_LEAD;
      cp_nxt    = '0;
      dl_nxt    = '0;
      neg_nxt   = 1'b0;
      bd_nxt    = '0;
      hn_nxt    = '0;
      ns_nxt    = 1'b0;
    end else begin
      phase_nxt = phase_step;
      cp_nxt    = cp_step;
      dl_nxt    = dl_step;
      neg_nxt   = neg_step;
      bd_nxt    = bd_step;
      hn_nxt    = hn_step;
      ns_nxt    = ns_step;
    end
  end

  // Result of this character, with the end-of-text verdict folded in.
  always_comb begin
    len_bad_step      = neg_step || (dl_step == '0) || (dl_step > MAX_LEN);
    result.byte_valid = c_nz && (phase_r == PH_HEX2) && hex_ok;
    result.byte_value = result.byte_valid ? {hn_r, hex_val} : 8'h00;
    result.byte_index = result.byte_valid ? bd_r[IDX_W-1:0] : '0;
    priority if (ended && (cp_step < CP_SAT)) begin
      result.status = ST_EMPTY;
    end else if (ended && (char_st == ST_BUSY)) begin
      unique case (phase_step)
        PH_NAME:           result.status = ST_TRUNC;
        PH_LWS, PH_LSIGN:  result.status = ST_BADLEN;
        PH_LDIG:           result.status = len_bad_step ? ST_BADLEN : ST_MALFORMED;
        PH_HEX1:           result.status = ns_step ? ST_BADTOKEN : ST_SHORT;
        PH_HEX2:           result.status = ST_BADTOKEN;
        PH_DONE:           result.status = ST_IGNORED;
        PH_LEAD:           result.status = ST_MALFORMED;
      endcase
    end else begin
      result.status = char_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      cp_r    <= '0;
      dl_r    <= '0;
      neg_r   <= 1'b0;
      bd_r    <= '0;
      hn_r    <= '0;
      ns_r    <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cp_r    <= cp_nxt;
      dl_r    <= dl_nxt;
      neg_r   <= neg_nxt;
      bd_r    <= bd_nxt;
      hn_r    <= hn_nxt;
      ns_r    <= ns_nxt;
    end
  end
endmodule

### hw/rtl/rphd_out_stage.sv
// Result register of the decoder: holds one result transaction until the sink takes it.
// Depends on rphd_pkg and rphd_out_if.
module rphd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rphd_pkg::out_item_t result,
  rphd_out_if.source          out_chan,
  output logic                load_ok
);
  import rphd_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  // Free when empty, or when the held result leaves this cycle.
  assign load_ok = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.byte_valid = item_r.byte_valid;
  assign out_chan.byte_value = item_r.byte_value;
  assign out_chan.byte_index = item_r.byte_index;
  assign out_chan.status     = item_r.status;
endmodule

### hw/rtl/raw_profile_hex_text_decoder_unit.sv
// Top level of the raw profile hex text decoder: input register, parser, result register.
// Depends on rphd_pkg, rphd_in_if, rphd_out_if, rphd_in_stage, rphd_parse, rphd_out_stage.
//
//   Channel   Direction  Payload                                      Per transaction
//   in_chan   sink       ch[7:0], final_char                          one character
//   out_chan  source     byte_valid, byte_value[7:0],                 one result
//                        byte_index[15:0], status[3:0]
//
// Each character yields exactly one result: the input register holds it, then the parser's
// single pass writes the result register. Throughput is one character per cycle while the
// result register is free, set by the parser state update (a multiply-by-ten accumulate
// and a compare on the length register) between the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to the
// leading-newline phase. A stalled result blocks only when the input register is also full;
// ready then drops and the held transaction stays in place.
module raw_profile_hex_text_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  rphd_in_if.sink    in_chan,
  rphd_out_if.source out_chan
);
  import rphd_pkg::*;

  in_item_t  held_item;
  out_item_t step_result;
  logic      held_valid;
  logic      out_free;
  logic      advance;

  // Move the held character through the parser only when its result has a slot.
  assign advance = held_valid && out_free;

  rphd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item       (held_item),
    .hold_valid (held_valid)
  );

  // Parser state advances only together with the result register load.
  rphd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (held_item),
    .advance (advance),
    .result  (step_result)
  );

  rphd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .result   (step_result),
    .out_chan (out_chan),
    .load_ok  (out_free)
  );
endmodule

### hw/rtl/rphd_checker.sv
// Port-level checker for the decoder, attached to the top level by the bind below.
// Depends on rphd_pkg and raw_profile_hex_text_decoder_unit.
module rphd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        byte_valid,
  input logic [7:0]  byte_value,
  input logic [15:0] byte_index,
  input logic [3:0]  status
);
  import rphd_pkg::*;

  // Hold a stalled result unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_valid) && $stable(byte_value) &&
                                $stable(byte_index) && $stable(status))
    else $error("stalled result changed");

  // A decoded byte comes only with busy, ok or short.
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_valid |-> (status == ST_BUSY) || (status == ST_OK) ||
                                (status == ST_SHORT))
    else $error("byte emitted with a terminal error status");

  // Drop value and index to zero on results without a byte.
  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> (byte_value == 8'h00) && (byte_index == 16'h0000))
    else $error("payload fields not cleared without a byte");

  // Results must never exceed the status code range.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_IGNORED)
    else $error("status code out of range");

  // Empty the result side on reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind raw_profile_hex_text_decoder_unit rphd_checker u_rphd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .byte_valid (out_chan.byte_valid),
  .byte_value (out_chan.byte_value),
  .byte_index (out_chan.byte_index),
  .status     (out_chan.status)
);

### tb/sv/raw_profile_hex_text_decoder_unit_tb.sv
// Self-checking testbench for the raw profile hex text decoder.
// Drives character streams through rphd_in_if and checks every result on rphd_out_if
// against a cycle-free predictor; depends on rphd_pkg, rphd_in_if, rphd_out_if and the DUT.
module raw_profile_hex_text_decoder_unit_tb;
  import rphd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 10;    // settling time once every result has landed
  localparam int HOLD_CYCLES  = 240;   // long receiver hold-off during the backpressure test
  localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction before the run is abandoned
  localparam int DEC_BASE     = 10;

  // Ways a text can end: flag on the last character, or a trailing NUL with or without flag.
  typedef enum logic [1:0] {END_FLAG, END_NUL, END_NUL_FLAG} text_end_t;

  localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};

  logic clk;
  logic rst_n;

  rphd_in_if  in_chan ();
  rphd_out_if out_chan ();

  raw_profile_hex_text_decoder_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Parser mirror: its own copy of the decoder state, advanced once per accepted transaction.
  // ---------------------------------------------------------------------------------------
  phase_t           prs_phase;
  logic [1:0]       prs_chars;   // characters seen in this text, saturating
  logic [CNT_W-1:0] prs_len;     // declared payload length, saturating above MAX_PAYLOAD
  logic             prs_neg;
  logic [CNT_W-1:0] prs_done;    // payload bytes decoded so far
  logic [3:0]       prs_hi;
  logic             prs_nl;      // a newline was skipped ahead of the current pair

  out_item_t  expected_results [$];
  logic [7:0] text_buf [$];

  int  mismatch_count = 0;
  int  chars_sent     = 0;
  int  texts_sent     = 0;
  int  bytes_checked  = 0;
  int  status_seen [16];
  bit  calm           = 1'b0;  // no idling on either side
  bit  hold_request   = 1'b0;  // ask the receiver for one long hold-off

  function automatic void clear_parser();
    prs_phase = PH_LEAD;
    prs_chars = '0;
    prs_len   = '0;
    prs_neg   = 1'b0;
    prs_done  = '0;
    prs_hi    = '0;
    prs_nl    = 1'b0;
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + int'(HEX_ALPHA_BASE);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + int'(HEX_ALPHA_BASE);
    return -1;
  endfunction

  // Verdict once the length digits stop; only a newline lets the payload start.
  function automatic status_t finish_length(input logic nl);
    if (prs_neg || prs_len == '0 || prs_len > MAX_LEN) return ST_BADLEN;
    if (!nl) return ST_MALFORMED;
    prs_phase = PH_HEX1;
    prs_nl    = 1'b0;
    return ST_BUSY;
  endfunction

  function automatic out_item_t decode_char(input logic [7:0] c, input logic fin);
    out_item_t r;
    status_t   st;
    int        h;
    int        acc;
    r  = '0;
    st = ST_BUSY;
    if (c != CH_NUL) begin
      if (prs_chars != CP_SAT) prs_chars++;
      case (prs_phase)
        PH_LEAD: begin
          // a bad first character is only reported once the text is long enough
          if (prs_chars == 2'd1 && c == CH_NL) begin
            prs_phase = PH_NAME;
          end else if (prs_chars == CP_SAT) begin
            st = ST_MALFORMED;
          end
        end
        PH_NAME: begin
          if (c == CH_NL) prs_phase = PH_LWS;
        end
        PH_LWS, PH_LSIGN: begin
          if (prs_phase == PH_LWS && (c == CH_SPACE || c == CH_TAB || c == CH_NL ||
                                      c == CH_VT || c == CH_FF || c == CH_CR)) begin
            // skip whitespace ahead of the length
          end else if (prs_phase == PH_LWS && (c == CH_PLUS || c == CH_MINUS)) begin
            prs_neg   = (c == CH_MINUS);
            prs_phase = PH_LSIGN;
          end else if (c >= CH_0 && c <= CH_9) begin
            prs_len   = CNT_W'(int'(c - CH_0));
            prs_phase = PH_LDIG;
          end else begin
            st = ST_BADLEN;
          end
        end
        PH_LDIG: begin
          if (c >= CH_0 && c <= CH_9) begin
            acc = int'(prs_len) * DEC_BASE + int'(c - CH_0);
            if (acc > MAX_PAYLOAD) acc = MAX_PAYLOAD + 1;
            prs_len = CNT_W'(acc);
          end else begin
            st = finish_length(c == CH_NL);
          end
        end
        PH_HEX1: begin
          if (c == CH_NL) begin
            prs_nl = 1'b1;
          end else begin
            h = nibble_of(c);
            if (h < 0) begin
              st = ST_BADTOKEN;
            end else begin
              prs_hi    = h[3:0];
              prs_phase = PH_HEX2;
            end
          end
        end
        PH_HEX2: begin
          h = nibble_of(c);
          if (h < 0) begin
            st = ST_BADTOKEN;
          end else begin
            r.byte_valid = 1'b1;
            r.byte_value = {prs_hi, h[3:0]};
            r.byte_index = prs_done[IDX_W-1:0];
            prs_done++;
            prs_nl    = 1'b0;
            prs_phase = PH_HEX1;
            if (prs_done >= prs_len) st = ST_OK;
          end
        end
        default: st = ST_IGNORED;
      endcase
      if (st != ST_BUSY) prs_phase = PH_DONE;
    end

    // End of text: a short text wins over everything, then an earlier verdict, then the phase.
    if (fin || c == CH_NUL) begin
      if (prs_chars != CP_SAT) begin
        st = ST_EMPTY;
      end else if (st == ST_BUSY) begin
        case (prs_phase)
          PH_NAME:          st = ST_TRUNC;
          PH_LWS, PH_LSIGN: st = ST_BADLEN;
          PH_LDIG:          st = finish_length(1'b0);
          PH_HEX1:          st = prs_nl ? ST_BADTOKEN : ST_SHORT;
          PH_HEX2:          st = ST_BADTOKEN;
          PH_DONE:          st = ST_IGNORED;
          default:          st = ST_MALFORMED;
        endcase
      end
      clear_parser();
    end
    r.status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender: one transaction per call, with an occasional random gap in front of it.
  // valid stays high between back-to-back characters so it is never dropped and raised
  // again within one time step.
  // ---------------------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic fin);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.ch         <= c;
    in_chan.final_char <= fin;
    do @(posedge clk); while (!in_chan.ready);
    expected_results.push_back(decode_char(c, fin));
    chars_sent++;
    if (fin || c == CH_NUL) texts_sent++;
  endtask

  // Append s to the text buffer, send the whole text and end it the requested way.
  task automatic send_str(input string s, input text_end_t how);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    foreach (text_buf[i]) send_char(text_buf[i], how == END_FLAG && i == text_buf.size() - 1);
    if (how != END_FLAG || text_buf.size() == 0) send_char(CH_NUL, how == END_NUL_FLAG);
    text_buf.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_0 + 8'(nib);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(nib) - HEX_ALPHA_BASE;
  endfunction

  // Build one random text: mostly well-formed profiles with random content, some of them
  // corrupted or cut, plus plain noise.
  task automatic build_profile_text(output text_end_t how);
    int    len_val;
    int    pairs;
    int    pick;
    string digits;
    logic [7:0] c;
    text_buf.delete();
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      text_buf.push_back(CH_NL);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(1, 255));
        text_buf.push_back(c == CH_NL ? CH_SPACE : c);
      end
      text_buf.push_back(CH_NL);
      repeat ($urandom_range(0, 2)) text_buf.push_back(BLANKS[$urandom_range(0, 5)]);
      pick = $urandom_range(0, 9);
      if (pick == 0) text_buf.push_back(CH_PLUS);
      else if (pick == 1) text_buf.push_back(CH_MINUS);

      pick = $urandom_range(0, 19);
      if (pick == 0) len_val = MAX_PAYLOAD;
      else if (pick == 1) len_val = MAX_PAYLOAD + 1 + $urandom_range(0, 999999);
      else if (pick == 2) len_val = 0;
      else len_val = $urandom_range(1, 12);
      digits = $sformatf("%0d", len_val);
      if ($urandom_range(0, 4) == 0) digits = {"0", digits};
      for (int i = 0; i < digits.len(); i++) text_buf.push_back(digits[i]);
      text_buf.push_back(CH_NL);

      // exact payload most of the time; some short, some with trailing pairs
      pick = $urandom_range(0, 19);
      if (len_val == 0 || len_val > 16) pairs = $urandom_range(0, 4);
      else if (pick < 3) pairs = $urandom_range(0, len_val - 1);
      else if (pick < 6) pairs = len_val + $urandom_range(1, 3);
      else pairs = len_val;
      repeat (pairs) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) text_buf.push_back(CH_NL);
        text_buf.push_back(hex_char(4'($urandom_range(0, 15))));
        text_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      if ($urandom_range(0, 5) == 0) text_buf.push_back(CH_NL);

      // corrupt one character or cut the text short
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        text_buf[$urandom_range(0, text_buf.size() - 1)] =
            ($urandom_range(0, 9) == 0) ? CH_NUL : 8'($urandom_range(1, 255));
      end else if (pick == 2) begin
        text_buf = text_buf[0:$urandom_range(0, text_buf.size() - 1)];
      end
    end
    pick = $urandom_range(0, 9);
    how = (pick == 0) ? END_NUL : (pick == 1) ? END_NUL_FLAG : END_FLAG;
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, always ready when calm.
  // ---------------------------------------------------------------------------------------
  initial begin : result_sink
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_request) begin
        // hold off long enough for the block to fill and drop in_chan.ready
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_chan.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction, field by field, with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      status_seen[out_chan.status]++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_chan.status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_chan.byte_valid !== want.byte_valid) begin
          $error("byte_valid expected %0d got %0d", want.byte_valid, out_chan.byte_valid);
          mismatch_count++;
        end
        if (out_chan.byte_value !== want.byte_value) begin
          $error("byte_value expected %0h got %0h", want.byte_value, out_chan.byte_value);
          mismatch_count++;
        end
        if (out_chan.byte_index !== want.byte_index) begin
          $error("byte_index expected %0d got %0d", want.byte_index, out_chan.byte_index);
          mismatch_count++;
        end
        if (out_chan.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_chan.status);
          mismatch_count++;
        end
        if (want.byte_valid) bytes_checked++;
      end
    end
  end

  // Abandon the run when neither channel moves for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Texts under three characters, including a lone NUL and the top character value.
  task automatic test_short_texts();
    send_str("", END_NUL);
    send_str("\n", END_FLAG);
    send_str("\n\n", END_NUL_FLAG);
    text_buf.push_back(8'hFF);
    send_str("", END_FLAG);
  endtask

  // Bad leading character, name cut by NUL, text ending before any length.
  task automatic test_header_errors();
    send_str("ab\n!", END_FLAG);
    send_str("\nname", END_NUL);
    send_str("\nx\n", END_FLAG);
  endtask

  // Missing digits, negative, zero, above the limit, saturating, unterminated lengths,
  // and every whitespace kind ahead of a valid one.
  task automatic test_length_errors();
    send_str("\nn\n +", END_FLAG);
    send_str("\nn\n-x", END_FLAG);
    send_str("\nn\n-5\n00", END_FLAG);
    send_str("\nn\n0\n", END_FLAG);
    send_str("\nn\n65537\n", END_FLAG);
    send_str("\nn\n99999999999\n", END_FLAG);
    send_str("\nn\n3x", END_FLAG);
    send_str("\nn\n3", END_FLAG);
    text_buf = {CH_NL, CH_NL, CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE, CH_NL};
    send_str("+1\nc3", END_FLAG);
  endtask

  // Largest length with a short payload, bad tokens, newline inside a pair, cut pairs,
  // trailing newlines, and characters after a completed payload.
  task automatic test_payload_cases();
    send_str("\nn\n65536\nAf", END_FLAG);
    send_str("\nn\n2\n0g", END_FLAG);
    send_str("\nn\n2\n0\n1", END_FLAG);
    send_str("\nn\n2\nF", END_FLAG);
    send_str("\nn\n3\n00\n\n", END_FLAG);
    send_str("\nn\n2\n\n00\nfF\nzz", END_FLAG);
    send_str("\nn\n1\n7e", END_NUL_FLAG);
  endtask

  task automatic test_random_texts(input int n_chars);
    text_end_t how;
    int        stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      build_profile_text(how);
      send_str("", how);
    end
  endtask

  // Keep offering characters while the receiver holds off, so the input stalls.
  task automatic test_backpressure();
    hold_request = 1'b1;
    test_random_texts(60);
  endtask

  // Close the run with no idling on either side.
  task automatic test_full_rate();
    calm = 1'b1;
    test_random_texts(150);
  endtask

  initial begin : stimulus
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_parser();
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.ch         = '0;
    in_chan.final_char = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_short_texts();
    test_header_errors();
    test_length_errors();
    test_payload_cases();
    test_random_texts(850);
    test_backpressure();
    test_full_rate();

    // drop valid, drain every outstanding result, then let the pipeline settle
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d texts, %0d characters and %0d decoded payload bytes.",
             texts_sent, chars_sent, bytes_checked);
    $display("Verdicts: ok %0d empty %0d malformed %0d truncated %0d badlen %0d badtoken %0d short %0d ignored %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_MALFORMED],
             status_seen[ST_TRUNC], status_seen[ST_BADLEN], status_seen[ST_BADTOKEN],
             status_seen[ST_SHORT], status_seen[ST_IGNORED]);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
